FILE: hw/rtl/pfs_pkg.sv
// ---------------------------------------------------------------------------
// Pyro firing sequencer package
// Shared types, codes and reset values for the sequencer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_DRIVE  = 2'd2
  } phase_t;

  // Error codes reported with each result word
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_MSG    = 3'd1,
    ERR_SUPPLY_UNK = 3'd2,
    ERR_SUPPLY_FLT = 3'd3,
    ERR_TYPE_UNK   = 3'd4
  } err_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_EMATCH_HOLD   = 3'd0;
  localparam logic [2:0] CFG_TALON_HOLD    = 3'd1;
  localparam logic [2:0] CFG_METRON_WINDOW = 3'd2;
  localparam logic [2:0] CFG_PULSE_HALF    = 3'd3;
  localparam logic [2:0] CFG_SETTLE        = 3'd4;
  localparam logic [2:0] CFG_BUS_THRESHOLD = 3'd5;

  // Configuration reset values
  localparam logic [15:0] RST_EMATCH_HOLD   = 16'd1500;
  localparam logic [15:0] RST_TALON_HOLD    = 16'd3000;
  localparam logic [15:0] RST_METRON_WINDOW = 16'd500;
  localparam logic [7:0]  RST_PULSE_HALF    = 8'd10;
  localparam logic [7:0]  RST_SETTLE        = 8'd2;
  localparam logic [11:0] RST_BUS_THRESHOLD = 12'd50;

  // Fire code low nibble: igniter type
  localparam logic [3:0] TYPE_OFF    = 4'h0;
  localparam logic [3:0] TYPE_EMATCH = 4'h1;
  localparam logic [3:0] TYPE_TALON  = 4'h2;
  localparam logic [3:0] TYPE_METRON = 4'h3;

  // Fire code high nibble: supply selection
  localparam logic [3:0] SUPPLY_1A = 4'h0;
  localparam logic [3:0] SUPPLY_3A = 4'h1;

  typedef struct packed {
    logic [15:0] ematch_hold;
    logic [15:0] talon_hold;
    logic [15:0] metron_window;
    logic [7:0]  pulse_half;
    logic [7:0]  settle;
    logic [11:0] bus_threshold;
  } cfg_t;

  // Classified input word passed from front to back
  typedef struct packed {
    logic        is_fire;   // enqueue request, otherwise a 1 ms tick
    logic [15:0] req_word;  // fire code in [15:8], channel in [7:0]
    logic        armed;
    logic        bus_low;   // bus reading below threshold
  } item_t;

  typedef struct packed {
    logic pause;
    logic high;
    logic low;
    logic drive;
  } flags_t;

  typedef struct packed {
    logic       channel_drive;
    logic [7:0] active_channel;
    logic       supply_low_en;
    logic       supply_high_en;
    logic       sensing_paused;
    logic       busy;
    err_t       error_code;
    logic       request_dropped;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pfs_ram.sv
// ---------------------------------------------------------------------------
// Pyro firing sequencer RAM
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module pfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pfs_front.sv
// ---------------------------------------------------------------------------
// Pyro firing sequencer front end
// Accepts input words, classifies them and buffers them in a two-entry queue.
// ---------------------------------------------------------------------------
`default_nettype none

module pfs_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          in_command,
  input  wire logic [7:0]    in_target_channel,
  input  wire logic [7:0]    in_fire_code,
  input  wire logic          in_armed,
  input  wire logic [11:0]   in_bus_reading,
  input  wire logic [11:0]   bus_threshold,
  output logic               item_valid,
  output pfs_pkg::item_t     item,
  input  wire logic          item_pop
);

  pfs_pkg::item_t buf_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  pfs_pkg::item_t classified;

  // Classify the incoming word
  always_comb begin
    classified.is_fire  = in_command;
    classified.req_word = {in_fire_code, in_target_channel};
    classified.armed    = in_armed;
    classified.bus_low  = (in_bus_reading < bus_threshold);
  end

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = buf_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = item_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, item_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold the classified word
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= classified;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pfs_back.sv
// ---------------------------------------------------------------------------
// Pyro firing sequencer back end
// Request queue, firing phase machine and the registered result word.
// ---------------------------------------------------------------------------
`default_nettype none

module pfs_back #(
  parameter int QUEUE_DEPTH = 128
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pfs_pkg::cfg_t  cfg,
  input  wire logic           item_valid,
  input  wire pfs_pkg::item_t item,
  output logic                item_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output pfs_pkg::result_t    result
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  pfs_pkg::phase_t   phase_r, phase_nxt;
  logic [15:0]       ptimer_r, ptimer_nxt;
  logic [7:0]        pulse_r, pulse_nxt;
  logic [15:0]       latched_r, latched_nxt;
  pfs_pkg::flags_t   flags_r, flags_nxt;
  logic              out_valid_r, out_valid_nxt;
  pfs_pkg::result_t  result_r, result_nxt;
  logic              byp_r, byp_nxt;
  logic [15:0]       byp_data_r;

  logic              fire;
  logic              wr_en;
  logic [15:0]       ram_q;
  logic [15:0]       head_word;
  logic [7:0]        half;
  pfs_pkg::err_t     err;
  logic              dropped;

  assign fire     = item_valid && (!out_valid_r || !out_stall);
  assign item_pop = fire;
  assign half     = (cfg.pulse_half == 8'd0) ? 8'd1 : cfg.pulse_half;

  // Request store; the read address follows the next head so the head word is ready
  pfs_ram #(
    .WIDTH (16),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (item.req_word),
    .rd_addr (head_nxt),
    .rd_data (ram_q)
  );

  assign byp_nxt   = wr_en && (tail_r == head_nxt);
  assign head_word = byp_r ? byp_data_r : ram_q;

  // Next state of queue and firing sequence
  always_comb begin
    logic        do_begin;
    logic [3:0]  btype;
    logic [3:0]  ptype;
    logic [3:0]  psup;
    logic [15:0] hold;

    do_begin    = 1'b0;
    btype       = pfs_pkg::TYPE_OFF;
    ptype       = head_word[11:8];
    psup        = head_word[15:12];
    hold        = 16'd0;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    phase_nxt   = phase_r;
    ptimer_nxt  = ptimer_r;
    pulse_nxt   = pulse_r;
    latched_nxt = latched_r;
    flags_nxt   = flags_r;
    err         = pfs_pkg::ERR_NONE;
    dropped     = 1'b0;
    wr_en       = 1'b0;

    if (fire) begin
      if (item.is_fire) begin
        // Enqueue, or drop when full
        if (count_r == FULL_CNT) begin
          dropped = 1'b1;
        end else begin
          wr_en     = 1'b1;
          tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        case (phase_r)
          pfs_pkg::PH_IDLE: begin
            // Pop and check one request
            if (count_r != '0) begin
              head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
              count_nxt = count_r - 1'b1;
              if (head_word == 16'd0) begin
                err = pfs_pkg::ERR_BAD_MSG;
              end else if (item.armed && ptype != pfs_pkg::TYPE_OFF) begin
                if (psup != pfs_pkg::SUPPLY_1A && psup != pfs_pkg::SUPPLY_3A) begin
                  err = pfs_pkg::ERR_SUPPLY_UNK;
                end else begin
                  latched_nxt     = head_word;
                  flags_nxt.pause = 1'b1;
                  flags_nxt.low   = (psup == pfs_pkg::SUPPLY_1A);
                  flags_nxt.high  = (psup == pfs_pkg::SUPPLY_3A);
                  flags_nxt.drive = 1'b0;
                  phase_nxt       = pfs_pkg::PH_SETTLE;
                  ptimer_nxt      = {8'd0, cfg.settle};
                  do_begin        = (cfg.settle == 8'd0);
                end
              end
            end
          end
          pfs_pkg::PH_SETTLE: begin
            // Count down the settle wait
            if (ptimer_r != 16'd0) begin
              ptimer_nxt = ptimer_r - 16'd1;
            end
            do_begin = (ptimer_nxt == 16'd0);
          end
          pfs_pkg::PH_DRIVE: begin
            if (latched_r[11:8] != pfs_pkg::TYPE_METRON) begin
              // Fixed hold
              if (ptimer_r != 16'd0) begin
                ptimer_nxt = ptimer_r - 16'd1;
              end
              if (ptimer_nxt == 16'd0) begin
                flags_nxt  = '0;
                phase_nxt  = pfs_pkg::PH_IDLE;
                pulse_nxt  = 8'd0;
              end
            end else begin
              // Metron pulsing
              if (ptimer_r != 16'hFFFF) begin
                ptimer_nxt = ptimer_r + 16'd1;
              end
              if (pulse_r != 8'd0) begin
                pulse_nxt = pulse_r - 8'd1;
              end
              if (pulse_nxt == 8'd0) begin
                if (flags_r.drive) begin
                  flags_nxt.drive = 1'b0;
                  pulse_nxt       = half;
                end else if (ptimer_nxt >= cfg.metron_window) begin
                  flags_nxt  = '0;
                  phase_nxt  = pfs_pkg::PH_IDLE;
                  ptimer_nxt = 16'd0;
                  pulse_nxt  = 8'd0;
                end else begin
                  flags_nxt.drive = 1'b1;
                  pulse_nxt       = half;
                end
              end
            end
          end
          default: begin
            flags_nxt  = '0;
            phase_nxt  = pfs_pkg::PH_IDLE;
            ptimer_nxt = 16'd0;
            pulse_nxt  = 8'd0;
          end
        endcase

        // Bus check and start of drive
        if (do_begin) begin
          btype = latched_nxt[11:8];
          if (item.bus_low) begin
            err            = pfs_pkg::ERR_SUPPLY_FLT;
            flags_nxt.low  = 1'b1;
            flags_nxt.high = 1'b1;
          end
          if (btype == pfs_pkg::TYPE_EMATCH || btype == pfs_pkg::TYPE_TALON) begin
            hold = (btype == pfs_pkg::TYPE_EMATCH) ? cfg.ematch_hold : cfg.talon_hold;
            if (hold == 16'd0) begin
              flags_nxt  = '0;
              phase_nxt  = pfs_pkg::PH_IDLE;
              ptimer_nxt = 16'd0;
              pulse_nxt  = 8'd0;
            end else begin
              flags_nxt.drive = 1'b1;
              phase_nxt       = pfs_pkg::PH_DRIVE;
              ptimer_nxt      = hold;
            end
          end else if (btype == pfs_pkg::TYPE_METRON) begin
            if (cfg.metron_window == 16'd0) begin
              flags_nxt  = '0;
              phase_nxt  = pfs_pkg::PH_IDLE;
              ptimer_nxt = 16'd0;
              pulse_nxt  = 8'd0;
            end else begin
              flags_nxt.drive = 1'b1;
              phase_nxt       = pfs_pkg::PH_DRIVE;
              ptimer_nxt      = 16'd0;
              pulse_nxt       = half;
            end
          end else begin
            err        = pfs_pkg::ERR_TYPE_UNK;
            flags_nxt  = '0;
            phase_nxt  = pfs_pkg::PH_IDLE;
            ptimer_nxt = 16'd0;
            pulse_nxt  = 8'd0;
          end
        end
      end
    end
  end

  // Result word from the state after this item
  always_comb begin
    result_nxt.channel_drive   = flags_nxt.drive;
    result_nxt.active_channel  = (phase_nxt != pfs_pkg::PH_IDLE) ? latched_nxt[7:0] : 8'd0;
    result_nxt.supply_low_en   = flags_nxt.low;
    result_nxt.supply_high_en  = flags_nxt.high;
    result_nxt.sensing_paused  = flags_nxt.pause;
    result_nxt.busy            = (phase_nxt != pfs_pkg::PH_IDLE);
    result_nxt.error_code      = err;
    result_nxt.request_dropped = dropped;
    out_valid_nxt              = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      phase_r     <= pfs_pkg::PH_IDLE;
      ptimer_r    <= 16'd0;
      pulse_r     <= 8'd0;
      latched_r   <= 16'd0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      ptimer_r    <= ptimer_nxt;
      pulse_r     <= pulse_nxt;
      latched_r   <= latched_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
      byp_r       <= byp_nxt;
    end
  end

  // Hold the result while stalled; capture bypass data
  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result_nxt;
    end
    byp_data_r <= item.req_word;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

FILE: hw/rtl/pyro_firing_sequencer_top.sv
// ---------------------------------------------------------------------------
// Pyro firing sequencer
// Queues fire requests and runs the supply, settle and drive sequence on ticks.
// ---------------------------------------------------------------------------
//  Port group   Direction  Handshake           Moves
//  in_*         input      in_valid/in_stall   one tick or fire request word
//  out_*        output     out_valid/out_stall one status word per input word
//  cfg_*        input      cfg_we              one register write
//
// One word is accepted per cycle while in_stall is low; each result is registered
// after its input word in the front queue, then in the back end's output register.
// The request store is a RAM read at the next head address, so a pop or an
// enqueue can complete every cycle in which the back end takes a word.
// Synchronous reset clears pointers, phase and flags; the RAM is not cleared.
// A stall on the result side fills the two-entry front queue and then stalls
// the input side.
// ---------------------------------------------------------------------------
`default_nettype none

module pyro_firing_sequencer_top #(
  parameter int QUEUE_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_target_channel,
  input  wire logic [7:0]  in_fire_code,
  input  wire logic        in_armed,
  input  wire logic [11:0] in_bus_reading,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_channel_drive,
  output logic [7:0]       out_active_channel,
  output logic             out_supply_low_en,
  output logic             out_supply_high_en,
  output logic             out_sensing_paused,
  output logic             out_busy_res,
  output logic [2:0]       out_error_code,
  output logic             out_request_dropped,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  pfs_pkg::cfg_t    cfg_r, cfg_nxt;
  logic             item_valid;
  pfs_pkg::item_t   item;
  logic             item_pop;
  pfs_pkg::result_t result;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pfs_pkg::CFG_EMATCH_HOLD:   cfg_nxt.ematch_hold   = cfg_wdata;
        pfs_pkg::CFG_TALON_HOLD:    cfg_nxt.talon_hold    = cfg_wdata;
        pfs_pkg::CFG_METRON_WINDOW: cfg_nxt.metron_window = cfg_wdata;
        pfs_pkg::CFG_PULSE_HALF:    cfg_nxt.pulse_half    = cfg_wdata[7:0];
        pfs_pkg::CFG_SETTLE:        cfg_nxt.settle        = cfg_wdata[7:0];
        pfs_pkg::CFG_BUS_THRESHOLD: cfg_nxt.bus_threshold = cfg_wdata[11:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ematch_hold   <= pfs_pkg::RST_EMATCH_HOLD;
      cfg_r.talon_hold    <= pfs_pkg::RST_TALON_HOLD;
      cfg_r.metron_window <= pfs_pkg::RST_METRON_WINDOW;
      cfg_r.pulse_half    <= pfs_pkg::RST_PULSE_HALF;
      cfg_r.settle        <= pfs_pkg::RST_SETTLE;
      cfg_r.bus_threshold <= pfs_pkg::RST_BUS_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pfs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_target_channel (in_target_channel),
    .in_fire_code      (in_fire_code),
    .in_armed          (in_armed),
    .in_bus_reading    (in_bus_reading),
    .bus_threshold     (cfg_r.bus_threshold),
    .item_valid        (item_valid),
    .item              (item),
    .item_pop          (item_pop)
  );

  pfs_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign out_channel_drive   = result.channel_drive;
  assign out_active_channel  = result.active_channel;
  assign out_supply_low_en   = result.supply_low_en;
  assign out_supply_high_en  = result.supply_high_en;
  assign out_sensing_paused  = result.sensing_paused;
  assign out_busy_res        = result.busy;
  assign out_error_code      = result.error_code;
  assign out_request_dropped = result.request_dropped;

endmodule

`default_nettype wire

FILE: hw/rtl/pfs_checker.sv
// ---------------------------------------------------------------------------
// Pyro firing sequencer checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module pfs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_channel_drive,
  input wire logic [7:0] out_active_channel,
  input wire logic       out_supply_low_en,
  input wire logic       out_supply_high_en,
  input wire logic       out_sensing_paused,
  input wire logic       out_busy_res,
  input wire logic [2:0] out_error_code,
  input wire logic       out_request_dropped
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word withdrawn while stalled");

  // Idle means drive, supplies, sensing pause and active channel are released
  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |->
      !out_channel_drive && !out_supply_low_en && !out_supply_high_en &&
      !out_sensing_paused && (out_active_channel == 8'd0))
    else $error("outputs active while idle");

  // Drive only with sensing paused and a supply on
  a_drive_safe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel_drive |->
      out_sensing_paused && (out_supply_low_en || out_supply_high_en))
    else $error("channel driven without paused sensing or supply");

  // A dropped request raises no error
  a_drop_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_dropped |-> (out_error_code == 3'd0))
    else $error("error reported on an enqueue word");

endmodule

bind pyro_firing_sequencer_top pfs_checker u_pfs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_channel_drive   (out_channel_drive),
  .out_active_channel  (out_active_channel),
  .out_supply_low_en   (out_supply_low_en),
  .out_supply_high_en  (out_supply_high_en),
  .out_sensing_paused  (out_sensing_paused),
  .out_busy_res        (out_busy_res),
  .out_error_code      (out_error_code),
  .out_request_dropped (out_request_dropped)
);

`default_nettype wire
